// File: design/lterec_pkg.sv
// ----------------------------------------------------------------------------
// lterec_pkg
// Shared widths, codes and defaults of the LTE resource element classifier.
// ----------------------------------------------------------------------------
package lterec_pkg;

    // Field widths of the word channels.
    localparam int SF_W     = 4;
    localparam int SYM_W    = 4;
    localparam int SC_W     = 11;
    localparam int RB_W     = 7;
    localparam int KIND_W   = 3;
    localparam int BIN_W    = 12;

    // Internal width for subcarrier sums and compares.
    localparam int CMP_W    = 13;

    // Configuration port.
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;

    // Default carrier limit.
    localparam int CARRIER_SC_CAP_DEF = 1200;

    // Element kinds.
    localparam logic [KIND_W-1:0] RE_UNUSED    = 3'd0;
    localparam logic [KIND_W-1:0] RE_SYNC      = 3'd1;
    localparam logic [KIND_W-1:0] RE_SYNC_GRD  = 3'd2;
    localparam logic [KIND_W-1:0] RE_REF       = 3'd3;
    localparam logic [KIND_W-1:0] RE_BCH       = 3'd4;

    // Register indexes (byte address divided by four).
    localparam logic [2:0] REG_NUM_RB      = 3'd0;
    localparam logic [2:0] REG_CELL_ID     = 3'd1;
    localparam logic [2:0] REG_ANT_PORTS   = 3'd2;
    localparam logic [2:0] REG_SYM_SLOT    = 3'd3;
    localparam logic [2:0] REG_CTRL_SYM    = 3'd4;
    localparam logic [2:0] REG_FFT_FIRST   = 3'd5;

    // Register reset values.
    localparam logic [6:0]  NUM_RB_RST     = 7'd6;
    localparam logic [8:0]  CELL_ID_RST    = 9'd0;
    localparam logic [2:0]  ANT_PORTS_RST  = 3'd1;
    localparam logic [2:0]  SYM_SLOT_RST   = 3'd7;
    localparam logic [2:0]  CTRL_SYM_RST   = 3'd1;
    localparam logic [10:0] FFT_FIRST_RST  = 11'd0;

    // Sync and broadcast band edges around the carrier centre.
    localparam int BAND_LO = 36;
    localparam int BAND_HI = 35;
    localparam int CORE_LO = 31;
    localparam int CORE_HI = 30;

endpackage

// File: design/lterec_req_if.sv
// ----------------------------------------------------------------------------
// lterec_req_if
// Input word channel: one resource element to classify.
// ----------------------------------------------------------------------------
interface lterec_req_if
    import lterec_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [SF_W-1:0]  subframe;
    logic [SYM_W-1:0] symbol;
    logic [SC_W-1:0]  subcarrier;
    logic [RB_W-1:0]  alloc_first_rb;
    logic [RB_W-1:0]  alloc_last_rb;

    modport source (
        output valid, subframe, symbol, subcarrier, alloc_first_rb, alloc_last_rb,
        input  ready
    );

    modport sink (
        input  valid, subframe, symbol, subcarrier, alloc_first_rb, alloc_last_rb,
        output ready
    );
endinterface

// File: design/lterec_rsp_if.sv
// ----------------------------------------------------------------------------
// lterec_rsp_if
// Output word channel: kind, take flag and FFT bin of one element.
// ----------------------------------------------------------------------------
interface lterec_rsp_if
    import lterec_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] re_kind;
    logic              take;
    logic [BIN_W-1:0]  fft_bin;

    modport source (
        output valid, re_kind, take, fft_bin,
        input  ready
    );

    modport sink (
        input  valid, re_kind, take, fft_bin,
        output ready
    );
endinterface

// File: design/lte_resource_element_classifier.sv
// ----------------------------------------------------------------------------
// lte_resource_element_classifier
// An accepted input word passes stage 1, stage 2, stage 3 and the output register in turn.
// Throughput: one word per cycle while rsp.ready holds; the four stage registers each hold a word,
// and a stage advances whenever the stage after it is empty or moving.
// Reset: rst_n clears all stage valid bits and loads the register defaults;
// no clearing pass is needed.
// ----------------------------------------------------------------------------
module lte_resource_element_classifier
    import lterec_pkg::*;
#(
    parameter int CARRIER_SC_CAP = CARRIER_SC_CAP_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    lterec_req_if.sink        req,
    lterec_rsp_if.source      rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    localparam int RB_MAX = CARRIER_SC_CAP / 12;

    // ------------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------------
    logic [6:0]  num_rb_reg;
    logic [8:0]  cell_id_reg;
    logic [2:0]  ant_ports_reg;
    logic [2:0]  sym_slot_reg;
    logic [2:0]  ctrl_sym_reg;
    logic [10:0] fft_first_reg;

    logic        wr_en;
    logic [2:0]  wr_idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign wr_idx = paddr[4:2];

    // Register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_rb_reg    <= NUM_RB_RST;
            cell_id_reg   <= CELL_ID_RST;
            ant_ports_reg <= ANT_PORTS_RST;
            sym_slot_reg  <= SYM_SLOT_RST;
            ctrl_sym_reg  <= CTRL_SYM_RST;
            fft_first_reg <= FFT_FIRST_RST;
        end
        else if (wr_en)
        begin
            case (wr_idx)
                REG_NUM_RB:    num_rb_reg    <= pwdata[6:0];
                REG_CELL_ID:   cell_id_reg   <= pwdata[8:0];
                REG_ANT_PORTS: ant_ports_reg <= pwdata[2:0];
                REG_SYM_SLOT:  sym_slot_reg  <= pwdata[2:0];
                REG_CTRL_SYM:  ctrl_sym_reg  <= pwdata[2:0];
                REG_FFT_FIRST: fft_first_reg <= pwdata[10:0];
                default:       ;
            endcase
        end
    end

    // Register reads.
    always_comb
    begin
        prdata = '0;
        case (wr_idx)
            REG_NUM_RB:    prdata = {25'd0, num_rb_reg};
            REG_CELL_ID:   prdata = {23'd0, cell_id_reg};
            REG_ANT_PORTS: prdata = {29'd0, ant_ports_reg};
            REG_SYM_SLOT:  prdata = {29'd0, sym_slot_reg};
            REG_CTRL_SYM:  prdata = {29'd0, ctrl_sym_reg};
            REG_FFT_FIRST: prdata = {21'd0, fft_first_reg};
            default:       prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------------
    // Derived carrier settings, registered so the stages see short paths.
    // The cell shift passes the product register and then the shift registers, the rest one
    // register; both settle before a word that follows a write reaches the stage that reads them.
    // ------------------------------------------------------------------------
    logic [6:0]       rb_next;
    logic [CMP_W-1:0] nsc_reg, nsc_next;
    logic [CMP_W-1:0] half_reg, half_next;
    logic [SYM_W-1:0] n_reg, n_next;
    logic             p2_reg, p2_next;
    logic             p3_reg, p3_next;
    logic             p4_reg, p4_next;
    logic [16:0]      cid_prod_reg, cid_prod_next;
    logic [8:0]       cid_d_reg;
    logic [3:0]       cid_rem;
    logic [2:0]       v_reg, v_next;
    logic [2:0]       w_reg, w_next;

    always_comb
    begin
        // Clamp the carrier size to the supported range.
        if (num_rb_reg < 7'd6)
            rb_next = 7'd6;
        else if (num_rb_reg > 7'(RB_MAX))
            rb_next = 7'(RB_MAX);
        else
            rb_next = num_rb_reg;
        nsc_next  = (CMP_W'(rb_next) << 3) + (CMP_W'(rb_next) << 2);
        half_next = (CMP_W'(rb_next) << 2) + (CMP_W'(rb_next) << 1);

        n_next  = (sym_slot_reg == 3'd6) ? 4'd6 : 4'd7;

        // A port count of zero acts as one, above four as four.
        p2_next = (ant_ports_reg >= 3'd2);
        p3_next = (ant_ports_reg >= 3'd3);
        p4_next = (ant_ports_reg >= 3'd4);

        // Cell id mod 6 by reciprocal: quotient from cid*170/1024 is at most
        // one short, so one subtract corrects the remainder. The product and
        // a copy of the id are registered together so they always match.
        cid_prod_next = 17'(cell_id_reg) * 17'd170;
        cid_rem = 4'(cid_d_reg - 9'((9'(cid_prod_reg[16:10]) << 2)
                                   + (9'(cid_prod_reg[16:10]) << 1)));
        v_next  = (cid_rem >= 4'd6) ? 3'(cid_rem - 4'd6) : cid_rem[2:0];
        w_next  = (v_next >= 3'd3) ? (v_next - 3'd3) : (v_next + 3'd3);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nsc_reg      <= CMP_W'(72);
            half_reg     <= CMP_W'(36);
            n_reg        <= 4'd7;
            p2_reg       <= 1'b0;
            p3_reg       <= 1'b0;
            p4_reg       <= 1'b0;
            cid_prod_reg <= '0;
            cid_d_reg    <= '0;
            v_reg        <= 3'd0;
            w_reg        <= 3'd3;
        end
        else
        begin
            nsc_reg      <= nsc_next;
            half_reg     <= half_next;
            n_reg        <= n_next;
            p2_reg       <= p2_next;
            p3_reg       <= p3_next;
            p4_reg       <= p4_next;
            cid_prod_reg <= cid_prod_next;
            cid_d_reg    <= cell_id_reg;
            v_reg        <= v_next;
            w_reg        <= w_next;
        end
    end

    // ------------------------------------------------------------------------
    // Stage handshake: a stage loads when it is empty or the stage after it can take a word.
    // ------------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, vo_reg;
    logic rdy1, rdy2, rdy3, rdyo;

    assign rdyo      = !vo_reg || rsp.ready;
    assign rdy3      = !v3_reg || rdyo;
    assign rdy2      = !v2_reg || rdy3;
    assign rdy1      = !v1_reg || rdy2;
    assign req.ready = rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= req.valid;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
            if (rdyo)
                vo_reg <= v3_reg;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 1: capture the word and start the subcarrier mod 6 product.
    // ------------------------------------------------------------------------
    logic [SF_W-1:0]  s1_sf_reg;
    logic [SYM_W-1:0] s1_l_reg;
    logic [SC_W-1:0]  s1_k_reg;
    logic [RB_W-1:0]  s1_a0_reg;
    logic [RB_W-1:0]  s1_a1_reg;
    logic [20:0]      s1_kprod_reg, s1_kprod_next;

    assign s1_kprod_next = 21'(req.subcarrier) * 21'd682;

    always_ff @(posedge clk)
    begin
        if (rdy1 && req.valid)
        begin
            s1_sf_reg    <= req.subframe;
            s1_l_reg     <= req.symbol;
            s1_k_reg     <= req.subcarrier;
            s1_a0_reg    <= req.alloc_first_rb;
            s1_a1_reg    <= req.alloc_last_rb;
            s1_kprod_reg <= s1_kprod_next;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 2: band position, allocation window, FFT bin and subcarrier mod 6.
    // ------------------------------------------------------------------------
    logic [SF_W-1:0]  s2_sf_reg;
    logic [SYM_W-1:0] s2_l_reg;
    logic [2:0]       s2_m_reg, s2_m_next;
    logic             s2_grid_reg, s2_grid_next;
    logic             s2_centre_reg, s2_centre_next;
    logic             s2_core_reg, s2_core_next;
    logic             s2_alloc_reg, s2_alloc_next;
    logic [BIN_W-1:0] s2_bin_reg, s2_bin_next;

    logic [CMP_W-1:0] k_w;
    logic [CMP_W-1:0] alloc_lo;
    logic [CMP_W-1:0] alloc_hi;
    logic [CMP_W-1:0] a1_inc;
    logic [CMP_W-1:0] bin_sum;
    logic [8:0]       kq;
    logic [SC_W:0]    k_rem;

    always_comb
    begin
        k_w = CMP_W'(s1_k_reg);

        // Quotient from k*682/4096 is at most one short of k/6.
        kq    = s1_kprod_reg[20:12];
        k_rem = (SC_W+1)'(s1_k_reg) - (((SC_W+1)'(kq) << 2) + ((SC_W+1)'(kq) << 1));
        s2_m_next = (k_rem >= 12'd6) ? 3'(k_rem - 12'd6) : k_rem[2:0];

        s2_grid_next   = (s1_l_reg < (n_reg << 1)) && (k_w < nsc_reg);
        s2_centre_next = (k_w + CMP_W'(BAND_LO) >= half_reg)
                      && (k_w <= half_reg + CMP_W'(BAND_HI));
        s2_core_next   = (k_w + CMP_W'(CORE_LO) >= half_reg)
                      && (k_w <= half_reg + CMP_W'(CORE_HI));

        // Localized allocation window in subcarriers.
        alloc_lo = (CMP_W'(s1_a0_reg) << 3) + (CMP_W'(s1_a0_reg) << 2);
        a1_inc   = CMP_W'(s1_a1_reg) + CMP_W'(1);
        alloc_hi = (a1_inc << 3) + (a1_inc << 2);
        s2_alloc_next = (s1_a0_reg <= s1_a1_reg) && (k_w >= alloc_lo) && (k_w < alloc_hi);

        // FFT bin skips the DC bin above the band centre.
        bin_sum = k_w + CMP_W'(fft_first_reg) + CMP_W'(k_w > half_reg);
        s2_bin_next = bin_sum[BIN_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (rdy2 && v1_reg)
        begin
            s2_sf_reg     <= s1_sf_reg;
            s2_l_reg      <= s1_l_reg;
            s2_m_reg      <= s2_m_next;
            s2_grid_reg   <= s2_grid_next;
            s2_centre_reg <= s2_centre_next;
            s2_core_reg   <= s2_core_next;
            s2_alloc_reg  <= s2_alloc_next;
            s2_bin_reg    <= s2_bin_next;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 3: kind by rule priority (broadcast over reference over sync) and take.
    // ------------------------------------------------------------------------
    logic [KIND_W-1:0] s3_kind_reg, s3_kind_next;
    logic              s3_take_reg, s3_take_next;
    logic [BIN_W-1:0]  s3_bin_reg;
    logic              rs_hit;
    logic              m_v;
    logic              m_w;

    always_comb
    begin
        m_v = (s2_m_reg == v_reg);
        m_w = (s2_m_reg == w_reg);

        // Reference signal pattern per symbol and port count.
        if (s2_l_reg == 4'd0 || s2_l_reg == n_reg)
            rs_hit = m_v || (p2_reg && m_w);
        else if (s2_l_reg == n_reg - 4'd3 || s2_l_reg == (n_reg << 1) - 4'd3)
            rs_hit = m_w || (p2_reg && m_v);
        else if (s2_l_reg == 4'd1)
            rs_hit = (p3_reg && m_v) || (p4_reg && m_w);
        else if (s2_l_reg == n_reg + 4'd1)
            rs_hit = (p3_reg && m_w) || (p4_reg && m_v);
        else
            rs_hit = 1'b0;

        s3_kind_next = RE_UNUSED;
        if (s2_grid_reg)
        begin
            if ((s2_sf_reg == 4'd0 || s2_sf_reg == 4'd5)
                && (s2_l_reg == n_reg - 4'd1 || s2_l_reg == n_reg - 4'd2)
                && s2_centre_reg)
                s3_kind_next = s2_core_reg ? RE_SYNC : RE_SYNC_GRD;
            if (rs_hit)
                s3_kind_next = RE_REF;
            if (s2_sf_reg == 4'd0 && s2_l_reg >= n_reg && s2_l_reg <= n_reg + 4'd3
                && s2_centre_reg)
                s3_kind_next = RE_BCH;
        end

        s3_take_next = s2_grid_reg && (s3_kind_next == RE_UNUSED)
                    && (s2_l_reg >= SYM_W'(ctrl_sym_reg)) && s2_alloc_reg;
    end

    always_ff @(posedge clk)
    begin
        if (rdy3 && v2_reg)
        begin
            s3_kind_reg <= s3_kind_next;
            s3_take_reg <= s3_take_next;
            s3_bin_reg  <= s2_bin_reg;
        end
    end

    // ------------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------------
    logic [KIND_W-1:0] out_kind_reg;
    logic              out_take_reg;
    logic [BIN_W-1:0]  out_bin_reg;

    always_ff @(posedge clk)
    begin
        if (rdyo && v3_reg)
        begin
            out_kind_reg <= s3_kind_reg;
            out_take_reg <= s3_take_reg;
            out_bin_reg  <= s3_bin_reg;
        end
    end

    assign rsp.valid   = vo_reg;
    assign rsp.re_kind = out_kind_reg;
    assign rsp.take    = out_take_reg;
    assign rsp.fft_bin = out_bin_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // Only an unused element is ever taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !(rsp.take && rsp.re_kind != RE_UNUSED))
        else $error("take set on a non-data element");

    // Input is refused only when every stage holds a word.
    assert property (@(posedge clk) disable iff (!rst_n)
        !req.ready |-> (v1_reg && v2_reg && v3_reg && vo_reg))
        else $error("input stalled with an empty stage");

    // A blocked stage keeps its word.
    assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && !rdyo) |=> v3_reg)
        else $error("stage 3 word dropped under stall");

    // The cell shifts stay in range.
    assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg < 3'd6) && (w_reg < 3'd6))
        else $error("reference shift out of range");

    // A word accepted into an empty pipeline is loaded into stage 1.
    assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && rsp.ready && !vo_reg && !v3_reg && !v2_reg
         && !v1_reg) |=> v1_reg)
        else $error("accepted word lost at stage 1");

endmodule
